FILE: rtl/core/spq_pkg.sv
// Package with the word types, codes and cell control struct of the sorted priority queue.
`default_nettype none

package spq_pkg;

   localparam logic CMD_INSERT = 1'b0;
   localparam logic CMD_REMOVE = 1'b1;

   localparam logic [1:0] ST_INSERTED = 2'd0;
   localparam logic [1:0] ST_FULL     = 2'd1;
   localparam logic [1:0] ST_REMOVED  = 2'd2;
   localparam logic [1:0] ST_EMPTY    = 2'd3;

   typedef struct packed {
      logic        cmd;
      logic [7:0]  priority_req;
      logic [15:0] payload;
   } req_word_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [7:0]  out_priority;
      logic [15:0] out_payload;
      logic [4:0]  fill_level;
   } rsp_word_type;

   typedef struct packed {
      logic [7:0]  prio;
      logic [15:0] data;
   } entry_type;

   typedef struct packed {
      logic      insert_en;
      logic      remove_en;
      entry_type new_entry;
   } cell_ctrl_type;

endpackage

`default_nettype wire

FILE: rtl/core/spq_cell.sv
// One slot of the sorted chain: holds an entry and shifts it left or right.
`default_nettype none

module spq_cell
   import spq_pkg::*;
(
   input  wire logic          clock,
   input  wire cell_ctrl_type ctrl,
   input  wire logic          occupied,
   input  wire entry_type     left_entry,
   input  wire logic          left_place,
   input  wire entry_type     right_entry,
   output entry_type          entry,
   output logic               place
);

   entry_type entry_ff;
   entry_type entry_in;

   // A slot is at or past the insert point when it is empty or holds a larger priority.
   assign place = !occupied || (entry_ff.prio > ctrl.new_entry.prio);

   always_comb begin
      entry_in = entry_ff;
      if (ctrl.insert_en && place) begin
         if (left_place) begin
            entry_in = left_entry;
         end else begin
            entry_in = ctrl.new_entry;
         end
      end else if (ctrl.remove_en) begin
         entry_in = right_entry;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry = entry_ff;

endmodule

`default_nettype wire

FILE: rtl/core/sorted_priority_queue_unit.sv
// Top level of the sorted priority queue built from a chain of slot cells.
`default_nettype none

// The queue keeps up to DEPTH priority/data pairs in ascending priority order in a row of
// cells; equal priorities leave in arrival order. All cells compare against the new
// priority and shift in the same clock, so one request word is accepted per cycle while
// req_ready is high, and its response word is in the output register in the next cycle.
// A new request is taken whenever the output register is empty or is being read in that cycle.
// Slot contents are undefined after reset; only the stored count and the valid flag are cleared.

module sorted_priority_queue_unit
   import spq_pkg::*;
#(
   parameter int DEPTH = 16
)
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   output logic              req_ready,
   input  wire req_word_type req_word,
   output logic              rsp_valid,
   input  wire logic         rsp_ready,
   output rsp_word_type      rsp_word
);

   localparam int CW = $clog2(DEPTH + 1);

   logic [CW-1:0] count_ff;
   logic [CW-1:0] count_in;
   logic          rsp_valid_ff;
   logic          rsp_valid_in;
   rsp_word_type  rsp_word_ff;
   rsp_word_type  rsp_word_in;

   logic          fire;
   logic          is_full;
   logic          is_empty;
   logic [CW+4:0] count_ext;
   cell_ctrl_type ctrl;

   entry_type     cell_entry [DEPTH];
   logic          cell_place [DEPTH];
   logic          occupied   [DEPTH];

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign fire      = req_valid && req_ready;
   assign is_full   = (count_ff == CW'(DEPTH));
   assign is_empty  = (count_ff == '0);

   assign ctrl.insert_en      = fire && (req_word.cmd == CMD_INSERT) && !is_full;
   assign ctrl.remove_en      = fire && (req_word.cmd == CMD_REMOVE) && !is_empty;
   assign ctrl.new_entry.prio = req_word.priority_req;
   assign ctrl.new_entry.data = req_word.payload;

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      entry_type left_entry;
      logic      left_place;
      entry_type right_entry;

      assign occupied[i] = (count_ff > CW'(i));

      if (i == 0) begin : g_first
         assign left_entry = ctrl.new_entry;
         assign left_place = 1'b0;
      end else begin : g_inner
         assign left_entry = cell_entry[i-1];
         assign left_place = cell_place[i-1];
      end

      if (i == DEPTH - 1) begin : g_last
         assign right_entry = cell_entry[i];
      end else begin : g_body
         assign right_entry = cell_entry[i+1];
      end

      spq_cell u_cell (
         .clock       (clock),
         .ctrl        (ctrl),
         .occupied    (occupied[i]),
         .left_entry  (left_entry),
         .left_place  (left_place),
         .right_entry (right_entry),
         .entry       (cell_entry[i]),
         .place       (cell_place[i])
      );
   end

   always_comb begin
      count_in = count_ff;
      if (ctrl.insert_en) begin
         count_in = count_ff + CW'(1);
      end else if (ctrl.remove_en) begin
         count_in = count_ff - CW'(1);
      end
   end

   assign count_ext = {5'b0, count_in};

   always_comb begin
      rsp_word_in              = rsp_word_ff;
      rsp_valid_in             = rsp_valid_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (fire) begin
         rsp_valid_in             = 1'b1;
         rsp_word_in.out_priority = '0;
         rsp_word_in.out_payload  = '0;
         rsp_word_in.fill_level   = count_ext[4:0];
         if (req_word.cmd == CMD_INSERT) begin
            rsp_word_in.status = is_full ? ST_FULL : ST_INSERTED;
         end else if (is_empty) begin
            rsp_word_in.status = ST_EMPTY;
         end else begin
            rsp_word_in.status       = ST_REMOVED;
            rsp_word_in.out_priority = cell_entry[0].prio;
            rsp_word_in.out_payload  = cell_entry[0].data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_word_ff <= rsp_word_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(DEPTH))
      else $error("Stored count exceeds the depth.");

   a_insert_count: assert property (@(posedge clock) disable iff (reset)
      ctrl.insert_en |=> (count_ff == $past(count_ff) + CW'(1)))
      else $error("Accepted insert did not raise the stored count.");

   a_empty_remove: assert property (@(posedge clock) disable iff (reset)
      (fire && (req_word.cmd == CMD_REMOVE) && is_empty) |=>
         (rsp_valid && (rsp_word.status == ST_EMPTY) && (rsp_word.out_priority == 8'd0)))
      else $error("Remove on an empty queue did not report empty.");

   a_idle_count: assert property (@(posedge clock) disable iff (reset)
      !fire |=> $stable(count_ff))
      else $error("Stored count changed without an accepted word.");

endmodule

`default_nettype wire

FILE: tb/sv/testbench.sv
// Self-checking testbench for the sorted priority queue unit.

module testbench
   import spq_pkg::*;
;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int QUEUE_DEPTH   = 16;
   localparam int RANDOM_WORDS  = 450;
   localparam int SEGMENT_WORDS = 25;
   localparam int HOLD_AT_WORD  = 150;
   localparam int HOLD_CYCLES   = 60;
   localparam int DRAIN_CYCLES  = 16;
   localparam int CYCLE_LIMIT   = 100000;

   class spq_scoreboard;
      logic [7:0]   slot_prio[QUEUE_DEPTH];
      logic [15:0]  slot_data[QUEUE_DEPTH];
      int           held;
      rsp_word_type pending[$];
      int           mismatches;
      int           words_checked;
      int           full_hits;
      int           empty_hits;
      int           peak_fill;

      function new();
         held = 0;
         mismatches = 0;
         words_checked = 0;
         full_hits = 0;
         empty_hits = 0;
         peak_fill = 0;
      endfunction

      function void note_request(req_word_type w);
         rsp_word_type r;
         int pos;
         r = '0;
         if (w.cmd == CMD_INSERT) begin
            if (held >= QUEUE_DEPTH) begin
               r.status = ST_FULL;
               full_hits++;
            end else begin
               pos = held;
               for (int k = 0; k < held; k++) begin
                  if (pos == held && slot_prio[k] > w.priority_req) begin
                     pos = k;
                  end
               end
               for (int k = held; k > pos; k--) begin
                  slot_prio[k] = slot_prio[k - 1];
                  slot_data[k] = slot_data[k - 1];
               end
               slot_prio[pos] = w.priority_req;
               slot_data[pos] = w.payload;
               held++;
               r.status = ST_INSERTED;
            end
         end else begin
            if (held == 0) begin
               r.status = ST_EMPTY;
               empty_hits++;
            end else begin
               r.out_priority = slot_prio[0];
               r.out_payload = slot_data[0];
               for (int k = 1; k < held; k++) begin
                  slot_prio[k - 1] = slot_prio[k];
                  slot_data[k - 1] = slot_data[k];
               end
               held--;
               r.status = ST_REMOVED;
            end
         end
         if (held > peak_fill) begin
            peak_fill = held;
         end
         r.fill_level = 5'(held);
         pending.push_back(r);
      endfunction

      function void compare_field(string name, int unsigned want, int unsigned got);
         if (want != got) begin
            mismatches++;
            $display("%0t: word %0d %s mismatch, expected %0h, got %0h",
                     $realtime, words_checked, name, want, got);
         end
      endfunction

      function void check_response(rsp_word_type got);
         rsp_word_type want;
         if (pending.size() == 0) begin
            mismatches++;
            $display("%0t: response word with none expected, expected nothing, got %h",
                     $realtime, got);
            return;
         end
         want = pending.pop_front();
         compare_field("status", want.status, got.status);
         compare_field("out_priority", want.out_priority, got.out_priority);
         compare_field("out_payload", want.out_payload, got.out_payload);
         compare_field("fill_level", want.fill_level, got.fill_level);
         words_checked++;
      endfunction
   endclass

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_ready;
   req_word_type req_word = '0;
   logic         rsp_valid;
   logic         rsp_ready = 1'b0;
   rsp_word_type rsp_word;

   spq_scoreboard sb = new();

   int send_gap_max = 9;
   int recv_gap_max = 9;
   int words_sent = 0;
   int words_received = 0;
   int cycle_count = 0;

   sorted_priority_queue_unit #(
      .DEPTH(QUEUE_DEPTH)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_word(req_word),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_word(rsp_word)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Run stopped after %0d cycles with %0d words outstanding.",
                  cycle_count, sb.pending.size());
         $display("TEST FAILED");
         $finish;
      end
   end

   function automatic req_word_type make_word(logic cmd, logic [7:0] prio,
                                              logic [15:0] data);
      req_word_type w;
      w.cmd = cmd;
      w.priority_req = prio;
      w.payload = data;
      return w;
   endfunction

   task automatic send_word(input req_word_type w);
      int gap;
      gap = $urandom_range(send_gap_max, 0);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_word <= w;
      do @(posedge clock); while (!req_ready);
      sb.note_request(w);
      words_sent++;
   endtask

   task automatic send_random_segment(input int count);
      int insert_pct;
      int prio_span;
      logic cmd;
      case ($urandom_range(2, 0))
         0: insert_pct = 25;
         1: insert_pct = 50;
         default: insert_pct = 75;
      endcase
      case ($urandom_range(2, 0))
         0: prio_span = 3;
         1: prio_span = 15;
         default: prio_span = 255;
      endcase
      send_gap_max = ($urandom_range(2, 0) == 0) ? 0 : 9;
      for (int i = 0; i < count; i++) begin
         cmd = ($urandom_range(99, 0) < insert_pct) ? CMD_INSERT : CMD_REMOVE;
         send_word(make_word(cmd, 8'($urandom_range(prio_span, 0)),
                             16'($urandom_range(16'hFFFF, 0))));
      end
   endtask

   initial begin
      int gap;
      bit held_off;
      held_off = 1'b0;
      while (reset) @(posedge clock);
      forever begin
         gap = $urandom_range(recv_gap_max, 0);
         if (!held_off && words_received >= HOLD_AT_WORD) begin
            gap = HOLD_CYCLES;
            held_off = 1'b1;
         end
         if (gap > 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
         sb.check_response(rsp_word);
         words_received++;
         if (words_received % 50 == 0) begin
            recv_gap_max = ($urandom_range(1, 0) == 0) ? 0 : 9;
         end
      end
   end

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Directed part: empty remove, extremes, ties, fill to full, reject, partial drain in order.
      send_word(make_word(CMD_REMOVE, 8'h00, 16'h0000));
      send_word(make_word(CMD_INSERT, 8'hFF, 16'hFFFF));
      send_word(make_word(CMD_INSERT, 8'h00, 16'h0000));
      send_word(make_word(CMD_INSERT, 8'h80, 16'h1234));
      send_word(make_word(CMD_INSERT, 8'h80, 16'h5678));
      send_word(make_word(CMD_INSERT, 8'h00, 16'hA5A5));
      send_word(make_word(CMD_INSERT, 8'h7F, 16'h5A5A));
      send_word(make_word(CMD_INSERT, 8'hFF, 16'h0001));
      for (int k = 0; k < 9; k++) begin
         send_word(make_word(CMD_INSERT, 8'(k * 29 + 3), 16'(16'hC000 + k)));
      end
      send_word(make_word(CMD_INSERT, 8'h00, 16'hDEAD));
      for (int k = 0; k < 5; k++) begin
         send_word(make_word(CMD_REMOVE, 8'hFF, 16'hFFFF));
      end

      for (int i = 0; i < RANDOM_WORDS; i += SEGMENT_WORDS) begin
         send_random_segment(SEGMENT_WORDS);
      end
      req_valid <= 1'b0;

      while (sb.pending.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Sent %0d request words and checked %0d response words, with a long",
               words_sent, sb.words_checked);
      $display("output stall; %0d full rejects, %0d empty removes, peak fill %0d.",
               sb.full_hits, sb.empty_hits, sb.peak_fill);
      if (sb.mismatches == 0 && sb.pending.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

FILE: files.f
rtl/core/spq_pkg.sv
rtl/core/spq_cell.sv
rtl/core/sorted_priority_queue_unit.sv
tb/sv/testbench.sv
